### hdl/gcl_pkg.sv
package gcl_pkg;

  localparam int CoordW = 32;
  localparam int IdxW   = 8;
  localparam int CountW = 9;
  localparam int NbNum  = 26;

  // register indexes of the configuration port
  localparam logic [2:0] RegOriginX = 3'd0;
  localparam logic [2:0] RegOriginY = 3'd1;
  localparam logic [2:0] RegOriginZ = 3'd2;
  localparam logic [2:0] RegInvX    = 3'd3;
  localparam logic [2:0] RegInvY    = 3'd4;
  localparam logic [2:0] RegInvZ    = 3'd5;
  localparam logic [2:0] RegCounts  = 3'd6;

  localparam logic FuncLocate = 1'b0;
  localparam logic FuncNeigh  = 1'b1;

  typedef struct packed {
    logic                     func;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic [IdxW-1:0]          home_x;
    logic [IdxW-1:0]          home_y;
    logic [IdxW-1:0]          home_z;
  } in_req_t;

  typedef struct packed {
    logic [IdxW-1:0] cell_x;
    logic [IdxW-1:0] cell_y;
    logic [IdxW-1:0] cell_z;
    logic            valid_res;
    logic            last;
  } out_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LSUB,
    ST_LMUL,
    ST_LCHK,
    ST_NSCAN,
    ST_NEND
  } state_t;

  // one neighbour offset, each axis a 2-bit signed step
  typedef struct packed {
    logic signed [1:0] dx;
    logic signed [1:0] dy;
    logic signed [1:0] dz;
  } nb_off_t;

  function automatic nb_off_t nb_off(input logic [4:0] idx);
    nb_off_t o;
    case (idx)
      5'd0:  o = '{-2'sd1,  2'sd0,  2'sd0};
      5'd1:  o = '{ 2'sd1,  2'sd0,  2'sd0};
      5'd2:  o = '{ 2'sd0,  2'sd1,  2'sd0};
      5'd3:  o = '{-2'sd1,  2'sd1,  2'sd0};
      5'd4:  o = '{ 2'sd1,  2'sd1,  2'sd0};
      5'd5:  o = '{ 2'sd0, -2'sd1,  2'sd0};
      5'd6:  o = '{-2'sd1, -2'sd1,  2'sd0};
      5'd7:  o = '{ 2'sd1, -2'sd1,  2'sd0};
      5'd8:  o = '{ 2'sd0,  2'sd0, -2'sd1};
      5'd9:  o = '{-2'sd1,  2'sd0, -2'sd1};
      5'd10: o = '{-2'sd1,  2'sd1, -2'sd1};
      5'd11: o = '{-2'sd1, -2'sd1, -2'sd1};
      5'd12: o = '{ 2'sd1,  2'sd0, -2'sd1};
      5'd13: o = '{ 2'sd1,  2'sd1, -2'sd1};
      5'd14: o = '{ 2'sd1, -2'sd1, -2'sd1};
      5'd15: o = '{ 2'sd0,  2'sd1, -2'sd1};
      5'd16: o = '{ 2'sd0, -2'sd1, -2'sd1};
      5'd17: o = '{ 2'sd0,  2'sd0,  2'sd1};
      5'd18: o = '{-2'sd1,  2'sd0,  2'sd1};
      5'd19: o = '{-2'sd1,  2'sd1,  2'sd1};
      5'd20: o = '{-2'sd1, -2'sd1,  2'sd1};
      5'd21: o = '{ 2'sd1,  2'sd0,  2'sd1};
      5'd22: o = '{ 2'sd1,  2'sd1,  2'sd1};
      5'd23: o = '{ 2'sd1, -2'sd1,  2'sd1};
      5'd24: o = '{ 2'sd0,  2'sd1,  2'sd1};
      5'd25: o = '{ 2'sd0, -2'sd1,  2'sd1};
      default: o = '{2'sd0, 2'sd0, 2'sd0};
    endcase
    return o;
  endfunction

endpackage

### hdl/gcl_mul.sv
module gcl_mul
  import gcl_pkg::*;
(
  input  logic                clk,
  input  logic                en,
  input  logic [CoordW-1:0]   a,
  input  logic [CoordW-1:0]   b,
  output logic [2*CoordW-1:0] p_r
);

  logic [2*CoordW-1:0] p_nxt;

  assign p_nxt = 64'(a) * 64'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

endmodule

### hdl/grid_cell_locate_and_neighbours.sv
// Locate request: accepted while idle, then busy for each axis in turn (subtract,
// multiply on the shared 32x32 multiplier, range check); result strobe in the cycle after the last check.
// Neighbour request: accepted while idle, then busy scanning the 26 offsets and one drain state;
// a hit is strobed the cycle after the next hit is found, the final one after the drain.
// A new request is taken only once the previous one is finished; the receiver cannot stall.
// Synchronous active-low reset restores the configuration registers and idles the block.
module grid_cell_locate_and_neighbours
  import gcl_pkg::*;
#(
  parameter int MAX_CELLS_AXIS = 256
)(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_req_t           in_req,
  output logic              out_valid,
  output out_res_t          out_res,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [CoordW-1:0] cfg_wdata
);

  localparam int AxisLimit = (MAX_CELLS_AXIS < 256) ? MAX_CELLS_AXIS : 256;

  logic [CoordW-1:0] org_x_r, org_y_r, org_z_r;
  logic [CoordW-1:0] inv_x_r, inv_y_r, inv_z_r;
  logic [26:0]       counts_r;

  state_t state_r, state_nxt;
  in_req_t req_r;
  logic [1:0]  ax_r, ax_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic        neg_r, neg_nxt;
  logic [32:0] mag_r, mag_nxt;
  logic        ok_r, ok_nxt;
  logic [IdxW-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic        have_r, have_nxt;
  out_res_t    pend_r, pend_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_res_t    out_res_r, out_res_nxt;

  logic [2*CoordW-1:0] prod;
  logic                mul_en;
  logic                accept;

  logic [CoordW-1:0]   sel_pos, sel_org, sel_inv;
  logic [CountW-1:0]   sel_cnt, nx, ny, nz;
  logic [32:0]         diff;
  logic [32:0]         cell_int;
  logic                axis_ok;
  nb_off_t             off;
  logic [9:0]          tx, ty, tz;
  logic                nb_in;

  function automatic logic [CountW-1:0] sat_count(input logic [CountW-1:0] c);
    return (c > CountW'(AxisLimit)) ? CountW'(AxisLimit) : c;
  endfunction

  assign nx = sat_count(counts_r[8:0]);
  assign ny = sat_count(counts_r[17:9]);
  assign nz = sat_count(counts_r[26:18]);

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r  <= '0;
      org_y_r  <= '0;
      org_z_r  <= '0;
      inv_x_r  <= 32'd65536;
      inv_y_r  <= 32'd65536;
      inv_z_r  <= 32'd65536;
      counts_r <= 27'd1049601;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegOriginX: org_x_r  <= cfg_wdata;
        RegOriginY: org_y_r  <= cfg_wdata;
        RegOriginZ: org_z_r  <= cfg_wdata;
        RegInvX:    inv_x_r  <= cfg_wdata;
        RegInvY:    inv_y_r  <= cfg_wdata;
        RegInvZ:    inv_z_r  <= cfg_wdata;
        RegCounts:  counts_r <= cfg_wdata[26:0];
        default: ;
      endcase
    end
  end

  // axis selection for the shared subtract / multiply path
  always_comb begin
    case (ax_r)
      2'd0: begin
        sel_pos = req_r.pos_x;
        sel_org = org_x_r;
        sel_inv = inv_x_r;
        sel_cnt = nx;
      end
      2'd1: begin
        sel_pos = req_r.pos_y;
        sel_org = org_y_r;
        sel_inv = inv_y_r;
        sel_cnt = ny;
      end
      default: begin
        sel_pos = req_r.pos_z;
        sel_org = org_z_r;
        sel_inv = inv_z_r;
        sel_cnt = nz;
      end
    endcase
  end

  assign diff   = {sel_pos[31], sel_pos} - {sel_org[31], sel_org};
  assign mul_en = (state_r == ST_LMUL);

  gcl_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mag_r[31:0]),
    .b   (sel_inv),
    .p_r (prod)
  );

  // the top magnitude bit adds a whole inv_pitch to the integer part
  assign cell_int = {1'b0, prod[63:32]} + (mag_r[32] ? {1'b0, sel_inv} : 33'd0);

  always_comb begin
    if (neg_r) begin
      axis_ok = (prod == '0) && !(mag_r[32] && (sel_inv != '0)) && (sel_cnt != '0);
    end else begin
      axis_ok = (cell_int < {24'd0, sel_cnt});
    end
  end

  assign off   = nb_off(idx_r);
  assign tx    = {2'b00, req_r.home_x} + {{8{off.dx[1]}}, off.dx};
  assign ty    = {2'b00, req_r.home_y} + {{8{off.dy[1]}}, off.dy};
  assign tz    = {2'b00, req_r.home_z} + {{8{off.dz[1]}}, off.dz};
  assign nb_in = !tx[9] && (tx[8:0] < nx) &&
                 !ty[9] && (ty[8:0] < ny) &&
                 !tz[9] && (tz[8:0] < nz);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_req.func == FuncNeigh) ? ST_NSCAN : ST_LSUB;
        end
      end
      ST_LSUB:  state_nxt = ST_LMUL;
      ST_LMUL:  state_nxt = ST_LCHK;
      ST_LCHK:  state_nxt = (ax_r == 2'd2) ? ST_IDLE : ST_LSUB;
      ST_NSCAN: state_nxt = (idx_r == 5'(NbNum - 1)) ? ST_NEND : ST_NSCAN;
      ST_NEND:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    ax_nxt        = ax_r;
    idx_nxt       = idx_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    ok_nxt        = ok_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    have_nxt      = have_r;
    pend_nxt      = pend_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    case (state_r)
      ST_IDLE: begin
        ax_nxt   = 2'd0;
        idx_nxt  = 5'd0;
        ok_nxt   = 1'b1;
        have_nxt = 1'b0;
      end
      ST_LSUB: begin
        neg_nxt = diff[32];
        mag_nxt = diff[32] ? (33'd0 - diff) : diff;
      end
      ST_LMUL: ;
      ST_LCHK: begin
        ok_nxt = ok_r && axis_ok;
        ax_nxt = ax_r + 2'd1;
        if (ax_r == 2'd0) begin
          cx_nxt = cell_int[7:0];
        end else if (ax_r == 2'd1) begin
          cy_nxt = cell_int[7:0];
        end else begin
          out_valid_nxt = 1'b1;
          if (ok_r && axis_ok) begin
            out_res_nxt = '{cx_r, cy_r, neg_r ? 8'd0 : cell_int[7:0], 1'b1, 1'b1};
          end else begin
            out_res_nxt = '{8'd0, 8'd0, 8'd0, 1'b0, 1'b1};
          end
          if (!neg_r && ok_r && axis_ok) begin
            out_res_nxt.cell_z = cell_int[7:0];
          end
        end
        // a negative offset that passes is index zero
        if (neg_r) begin
          if (ax_r == 2'd0) begin
            cx_nxt = '0;
          end else if (ax_r == 2'd1) begin
            cy_nxt = '0;
          end
        end
      end
      ST_NSCAN: begin
        idx_nxt = idx_r + 5'd1;
        // hold one hit back so the final one can carry last
        if (nb_in) begin
          if (have_r) begin
            out_valid_nxt = 1'b1;
            out_res_nxt   = pend_r;
          end
          pend_nxt = '{tx[7:0], ty[7:0], tz[7:0], 1'b1, 1'b0};
          have_nxt = 1'b1;
        end
      end
      ST_NEND: begin
        out_valid_nxt = 1'b1;
        if (have_r) begin
          out_res_nxt      = pend_r;
          out_res_nxt.last = 1'b1;
        end else begin
          out_res_nxt = '{8'd0, 8'd0, 8'd0, 1'b0, 1'b1};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      have_r      <= 1'b0;
      ax_r        <= 2'd0;
      idx_r       <= 5'd0;
      ok_r        <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      have_r      <= have_nxt;
      ax_r        <= ax_nxt;
      idx_r       <= idx_nxt;
      ok_r        <= ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
    end
    neg_r     <= neg_nxt;
    mag_r     <= mag_nxt;
    cx_r      <= cx_nxt;
    cy_r      <= cy_nxt;
    pend_r    <= pend_nxt;
    out_res_r <= out_res_nxt;
  end

  a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_LCHK || state_r == ST_NSCAN || state_r == ST_NEND))
    else $error("result strobe without work in progress");

  a_last_ends_request: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.last) |-> (state_r == ST_IDLE))
    else $error("last result while sequencer still busy");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_res.valid_res) |->
      (out_res.cell_x == '0 && out_res.cell_y == '0 && out_res.cell_z == '0 && out_res.last))
    else $error("empty result carries cell data or lacks last");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_NSCAN) |-> (idx_r < 5'(NbNum)))
    else $error("neighbour index past table");

endmodule

### sim/grid_cell_locate_and_neighbours_test.sv
module grid_cell_locate_and_neighbours_test
  import gcl_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int AxisMax = 256;

  // neighbour walk: in-plane ring first, then the layer below, then the layer above
  localparam int StepX [26] = '{-1, 1, 0, -1, 1, 0, -1, 1,
                                0, -1, -1, -1, 1, 1, 1, 0, 0,
                                0, -1, -1, -1, 1, 1, 1, 0, 0};
  localparam int StepY [26] = '{0, 0, 1, 1, 1, -1, -1, -1,
                                0, 0, 1, -1, 0, 1, -1, 1, -1,
                                0, 0, 1, -1, 0, 1, -1, 1, -1};
  localparam int StepZ [26] = '{0, 0, 0, 0, 0, 0, 0, 0,
                                -1, -1, -1, -1, -1, -1, -1, -1, -1,
                                1, 1, 1, 1, 1, 1, 1, 1, 1};

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  in_req_t           in_req = '0;
  logic              out_valid;
  out_res_t          out_res;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [2:0]        cfg_index = RegOriginX;
  logic [CoordW-1:0] cfg_wdata = '0;

  // copy of the block's registers as last written
  logic signed [31:0] org_m [3] = '{32'sd0, 32'sd0, 32'sd0};
  logic [31:0]        inv_m [3] = '{32'd65536, 32'd65536, 32'd65536};
  logic [26:0]        counts_m = 27'd1049601;

  in_req_t  requests_pending [$];
  out_res_t cell_results_due [$];
  out_res_t want_res;
  logic     loaded = 1'b0;
  int       hold_left = 0;
  int       idle_pct = 0;
  int       results_seen = 0;
  int       mismatches = 0;

  grid_cell_locate_and_neighbours dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic int axis_limit(input int a);
    int c;
    c = counts_m[9*a +: 9];
    return (c > AxisMax) ? AxisMax : c;
  endfunction

  function automatic bit locate_one(input logic [31:0] p, input logic [31:0] o,
                                    input logic [31:0] r, input int n,
                                    output logic [7:0] idx);
    logic [33:0] d;
    logic [32:0] mag;
    logic [64:0] prod;
    logic [32:0] whole;
    idx = '0;
    d = {{2{p[31]}}, p} - {{2{o[31]}}, o};
    mag = d[33] ? 33'(-d) : d[32:0];
    prod = 65'(mag) * 65'(r);
    // below the origin only a zero product lands in cell 0
    if (d[33] && prod != '0)
      return 1'b0;
    whole = d[33] ? '0 : prod[64:32];
    if (whole >= 33'(n))
      return 1'b0;
    idx = whole[7:0];
    return 1'b1;
  endfunction

  function automatic void derive_cells(input in_req_t req);
    logic [7:0] cx, cy, cz;
    bit         okx, oky, okz;
    int         nx, ny, nz, x, y, z;
    out_res_t   res;
    out_res_t   batch [$];
    nx = axis_limit(0);
    ny = axis_limit(1);
    nz = axis_limit(2);
    if (req.func == FuncLocate) begin
      okx = locate_one(req.pos_x, org_m[0], inv_m[0], nx, cx);
      oky = locate_one(req.pos_y, org_m[1], inv_m[1], ny, cy);
      okz = locate_one(req.pos_z, org_m[2], inv_m[2], nz, cz);
      res = '0;
      if (okx && oky && okz) begin
        res.cell_x = cx;
        res.cell_y = cy;
        res.cell_z = cz;
        res.valid_res = 1'b1;
      end
      batch = {batch, res};
    end else begin
      for (int k = 0; k < 26; k++) begin
        x = int'(req.home_x) + StepX[k];
        y = int'(req.home_y) + StepY[k];
        z = int'(req.home_z) + StepZ[k];
        if (x >= 0 && x < nx && y >= 0 && y < ny && z >= 0 && z < nz) begin
          res = '0;
          res.cell_x = 8'(x);
          res.cell_y = 8'(y);
          res.cell_z = 8'(z);
          res.valid_res = 1'b1;
          batch = {batch, res};
        end
      end
      if (batch.size() == 0)
        batch = {batch, out_res_t'('0)};
    end
    batch[batch.size() - 1].last = 1'b1;
    cell_results_due = {cell_results_due, batch};
  endfunction

  function automatic logic [31:0] pick_pos(input int a);
    logic [63:0] span;
    logic [31:0] d;
    if (inv_m[a] == '0)
      span = 64'h10_0000;
    else
      span = (64'(axis_limit(a)) << 32) / inv_m[a];
    if (span > 64'h7FFF_FFFF)
      span = 64'h7FFF_FFFF;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: d = 32'(span) + $urandom_range(0, 2) - 1;
      2: d = $urandom_range(0, 2) - 1;
      default: d = $urandom_range(0, 32'(span + span / 8));
    endcase
    return org_m[a] + d;
  endfunction

  function automatic logic [7:0] pick_home(input int a);
    int n;
    n = axis_limit(a);
    case ($urandom_range(0, 9))
      0: return 8'($urandom);
      1: return 8'(n);
      2: return 8'(n - 1);
      default: return (n == 0) ? 8'($urandom) : 8'($urandom_range(0, n - 1));
    endcase
  endfunction

  function automatic in_req_t random_req();
    in_req_t r;
    r.func = ($urandom_range(0, 1) != 0) ? FuncNeigh : FuncLocate;
    r.pos_x = pick_pos(0);
    r.pos_y = pick_pos(1);
    r.pos_z = pick_pos(2);
    r.home_x = pick_home(0);
    r.home_y = pick_home(1);
    r.home_z = pick_home(2);
    return r;
  endfunction

  function automatic in_req_t loc_req(input logic [31:0] x, y, z);
    in_req_t r;
    r = random_req();
    r.func = FuncLocate;
    r.pos_x = x;
    r.pos_y = y;
    r.pos_z = z;
    return r;
  endfunction

  function automatic in_req_t nbr_req(input logic [7:0] x, y, z);
    in_req_t r;
    r = random_req();
    r.func = FuncNeigh;
    r.home_x = x;
    r.home_y = y;
    r.home_z = z;
    return r;
  endfunction

  function automatic logic [26:0] pack_counts(input logic [8:0] x, y, z);
    return {z, y, x};
  endfunction

  function automatic logic [31:0] random_origin();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] random_recip();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return $urandom;
      default: return $urandom_range(32'h1000, 32'h10_0000);
    endcase
  endfunction

  function automatic logic [8:0] random_count();
    case ($urandom_range(0, 7))
      0: return 9'($urandom);
      1: return 9'd256;
      default: return 9'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 100)
      $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // called at a rising edge; returns at the edge that took the write
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      RegOriginX: org_m[0] = val;
      RegOriginY: org_m[1] = val;
      RegOriginZ: org_m[2] = val;
      RegInvX:    inv_m[0] = val;
      RegInvY:    inv_m[1] = val;
      RegInvZ:    inv_m[2] = val;
      RegCounts:  counts_m = val[26:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [31:0] ox, oy, oz, ix, iy, iz,
                               input logic [26:0] cnt);
    @(posedge clk);
    write_reg(RegOriginX, ox);
    write_reg(RegOriginY, oy);
    write_reg(RegOriginZ, oz);
    write_reg(RegInvX, ix);
    write_reg(RegInvY, iy);
    write_reg(RegInvZ, iz);
    // spare upper bits of the counts word are don't-care; toggle them anyway
    write_reg(RegCounts, {5'($urandom), cnt});
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_req(input in_req_t r);
    requests_pending = {requests_pending, r};
  endtask

  task automatic queue_random(input int count);
    repeat (count) queue_req(random_req());
  endtask

  task automatic drain();
    do @(negedge clk);
    while (requests_pending.size() != 0 || loaded || cell_results_due.size() != 0);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      loaded = 1'b0;
      hold_left = 0;
    end else begin
      if (start && !busy) begin
        derive_cells(in_req);
        loaded = 1'b0;
      end
      if (!loaded && requests_pending.size() != 0) begin
        in_req <= requests_pending.pop_front();
        loaded = 1'b1;
      end
      if (hold_left == 0 && idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        hold_left = $urandom_range(1, 5);
      if (hold_left != 0) begin
        hold_left--;
        start <= 1'b0;
      end else begin
        start <= loaded;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (cell_results_due.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", out_res));
      end else begin
        want_res = cell_results_due.pop_front();
        if (out_res.cell_x !== want_res.cell_x)
          report_mismatch($sformatf("result %0d cell_x %h, want %h",
                                    results_seen, out_res.cell_x, want_res.cell_x));
        if (out_res.cell_y !== want_res.cell_y)
          report_mismatch($sformatf("result %0d cell_y %h, want %h",
                                    results_seen, out_res.cell_y, want_res.cell_y));
        if (out_res.cell_z !== want_res.cell_z)
          report_mismatch($sformatf("result %0d cell_z %h, want %h",
                                    results_seen, out_res.cell_z, want_res.cell_z));
        if (out_res.valid_res !== want_res.valid_res)
          report_mismatch($sformatf("result %0d valid_res %b, want %b",
                                    results_seen, out_res.valid_res, want_res.valid_res));
        if (out_res.last !== want_res.last)
          report_mismatch($sformatf("result %0d last %b, want %b",
                                    results_seen, out_res.last, want_res.last));
      end
      results_seen++;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset grid: 1 x 2 x 4 cells of unit length at the origin
    idle_pct = 10;
    queue_req(loc_req(32'h0, 32'h0, 32'h0));
    queue_req(loc_req(32'h0000_FFFF, 32'h0001_8000, 32'h0003_FFFF));
    queue_req(loc_req(32'h0001_0000, 32'h0, 32'h0));
    queue_req(loc_req(32'h0, 32'h0, 32'h0004_0000));
    queue_req(loc_req(32'hFFFF_FFFF, 32'h0, 32'h0));
    queue_req(loc_req(32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
    queue_req(nbr_req(8'd0, 8'd0, 8'd0));
    queue_req(nbr_req(8'd0, 8'd1, 8'd3));
    queue_req(nbr_req(8'd1, 8'd2, 8'd4));
    queue_req(nbr_req(8'd255, 8'd255, 8'd255));
    queue_req(nbr_req(8'd0, 8'd0, 8'd2));
    queue_random(40);
    drain();

    // oversized counts saturate to a full grid of 256 cells per axis
    idle_pct = 0;
    apply_setting(32'h0, 32'h0, 32'h0, 32'd65536, 32'd65536, 32'd65536, 27'h7FF_FFFF);
    queue_req(nbr_req(8'd1, 8'd1, 8'd1));
    queue_req(nbr_req(8'd255, 8'd255, 8'd255));
    queue_req(nbr_req(8'd0, 8'd0, 8'd0));
    queue_req(loc_req(32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF));
    queue_req(loc_req(32'h0100_0000, 32'h0, 32'h0));
    queue_random(60);
    drain();

    // empty y axis: nothing can be found
    idle_pct = 15;
    apply_setting(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'd65536,
                  pack_counts(9'd3, 9'd0, 9'd5));
    queue_req(loc_req(32'h0, 32'h0, 32'h0));
    queue_req(nbr_req(8'd1, 8'd0, 8'd1));
    queue_random(20);
    drain();

    // zero reciprocal on x: a position below the origin still lands in cell 0
    idle_pct = 8;
    apply_setting(32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0, 32'h0000_8000, 32'hFFFF_FFFF,
                  pack_counts(9'd2, 9'd256, 9'd256));
    queue_req(loc_req(32'h8000_0000, 32'h01FF_FFFF, 32'h8000_0000));
    queue_random(40);
    drain();

    for (int p = 0; p < 5; p++) begin
      idle_pct = (p == 2) ? 0 : $urandom_range(3, 15);
      apply_setting(random_origin(), random_origin(), random_origin(),
                    random_recip(), random_recip(), random_recip(),
                    pack_counts(random_count(), random_count(), random_count()));
      queue_random(60);
      drain();
    end

    // closing stretch back at the reset grid, no idling
    idle_pct = 0;
    apply_setting(32'h0, 32'h0, 32'h0, 32'd65536, 32'd65536, 32'd65536,
                  pack_counts(9'd1, 9'd2, 9'd4));
    queue_random(60);
    drain();

    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("grid_cell_locate_and_neighbours_test passed");
    else
      $display("grid_cell_locate_and_neighbours_test failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("grid_cell_locate_and_neighbours_test failed");
    $finish;
  end

endmodule
